@@ rtl/yuv_to_rgb_pixel_converter_defines.svh @@
// Assertion macros shared by the pixel converter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef YUV_TO_RGB_PIXEL_CONVERTER_DEFINES_SVH
`define YUV_TO_RGB_PIXEL_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define Y2R_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define Y2R_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/y2r_pkg.sv @@
// Package for the YUV to RGB pixel converter: register indexes, mode codes,
// coefficient sets and the channel clip function. Depends on nothing.
`timescale 1ns / 1ps

package y2r_pkg;

   localparam int unsigned ChannelWidth = 8;
   localparam int unsigned CoefWidth    = 12;
   localparam int unsigned CoefShift    = 10;
   localparam int unsigned SumWidth     = 11;

   localparam logic [7:0] CHROMA_OFFSET = 8'd128;
   localparam logic [7:0] CHANNEL_MAX   = 8'hFF;

   localparam logic CSR_COLOR_MODE  = 1'b0;
   localparam logic CSR_SWAP_CHROMA = 1'b1;

   localparam logic [1:0] MODE_WINDOWS = 2'd0;
   localparam logic [1:0] MODE_PAL     = 2'd1;
   localparam logic [1:0] MODE_V4L2    = 2'd2;
   localparam logic [1:0] MODE_GREY    = 2'd3;

   typedef struct packed {
      logic [CoefWidth-1:0] rv;
      logic [CoefWidth-1:0] gu;
      logic [CoefWidth-1:0] gv;
      logic [CoefWidth-1:0] bu;
   } coef_set_type;

   function automatic coef_set_type coef_lookup(input logic [1:0] mode);
      coef_set_type set;
      unique case (mode)
         MODE_WINDOWS: set = '{rv: 12'd1632, gu: 12'd400, gv: 12'd528, bu: 12'd2064};
         MODE_PAL:     set = '{rv: 12'd1168, gu: 12'd408, gv: 12'd594, bu: 12'd2080};
         MODE_V4L2:    set = '{rv: 12'd1440, gu: 12'd352, gv: 12'd736, bu: 12'd1816};
         MODE_GREY:    set = '{rv: 12'd0,    gu: 12'd0,   gv: 12'd0,   bu: 12'd0};
         default:      set = '{rv: 12'd0,    gu: 12'd0,   gv: 12'd0,   bu: 12'd0};
      endcase
      return set;
   endfunction

   function automatic logic [ChannelWidth-1:0] clip_channel(input logic signed [SumWidth-1:0] x);
      logic [ChannelWidth-1:0] res;
      priority if (x < 0) begin
         res = '0;
      end else if (x > $signed({3'b000, CHANNEL_MAX})) begin
         res = CHANNEL_MAX;
      end else begin
         res = x[ChannelWidth-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/yuv_to_rgb_pixel_converter.sv @@
// Top level of the YUV 4:2:0 to RGB24 pixel converter.
// Depends on y2r_pkg and yuv_to_rgb_pixel_converter_defines.svh.
`timescale 1ns / 1ps
`include "yuv_to_rgb_pixel_converter_defines.svh"

// Usage:
// The request channel carries one pixel per transfer: a luma byte and the
// two chroma bytes of its 2x2 block. The response channel returns one RGB24
// pixel per request, in order. Both channels transfer when valid is high and
// stall is low.
// Each pixel passes an input register and then a result register before its response
// is valid. One pixel is accepted every cycle as long as the response side does not
// stall; between the two registers lies a single combinational pass of four narrow
// multiplies, adds and clips.
// When the response side stalls, the held result stays on the outputs and an
// empty input register still takes one more pixel; after that req_stall is raised.
// The csr port sets the coefficient mode and the chroma plane order; write it
// only while no pixel is in flight. Synchronous reset empties both registers
// and returns the mode to the first coefficient set with no plane swap.
module yuv_to_rgb_pixel_converter
   import y2r_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_luma,
   input  logic [7:0] req_first_chroma,
   input  logic [7:0] req_second_chroma,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_blue_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_red_out,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [1:0] csr_wdata
);

   logic [1:0] color_mode_ff, color_mode_in;
   logic       swap_chroma_ff, swap_chroma_in;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_luma_ff, s1_luma_in;
   logic [7:0] s1_first_ff, s1_first_in;
   logic [7:0] s1_second_ff, s1_second_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_blue_ff, rsp_blue_in;
   logic [7:0] rsp_green_ff, rsp_green_in;
   logic [7:0] rsp_red_ff, rsp_red_in;

   logic out_free;
   logic s1_move;
   logic req_take;

   coef_set_type coef;
   logic signed [8:0]  c1, c2, u, v;
   logic signed [21:0] p_rv, p_gu, p_gv, p_bu;
   logic signed [SumWidth-1:0] t_rv, t_gu, t_gv, t_bu;
   logic signed [SumWidth-1:0] y_ext, r_sum, g_sum, b_sum;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      color_mode_in  = color_mode_ff;
      swap_chroma_in = swap_chroma_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COLOR_MODE:  color_mode_in  = csr_wdata;
            CSR_SWAP_CHROMA: swap_chroma_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
      s1_luma_in   = req_take ? req_luma : s1_luma_ff;
      s1_first_in  = req_take ? req_first_chroma : s1_first_ff;
      s1_second_in = req_take ? req_second_chroma : s1_second_ff;
   end

   always_comb begin
      coef = coef_lookup(color_mode_ff);
      c1   = $signed({1'b0, s1_first_ff}) - $signed({1'b0, CHROMA_OFFSET});
      c2   = $signed({1'b0, s1_second_ff}) - $signed({1'b0, CHROMA_OFFSET});
      u    = swap_chroma_ff ? c1 : c2;
      v    = swap_chroma_ff ? c2 : c1;

      p_rv = 22'(v * $signed({1'b0, coef.rv}));
      p_gu = 22'(u * $signed({1'b0, coef.gu}));
      p_gv = 22'(v * $signed({1'b0, coef.gv}));
      p_bu = 22'(u * $signed({1'b0, coef.bu}));

      t_rv = SumWidth'(p_rv >>> CoefShift);
      t_gu = SumWidth'(p_gu >>> CoefShift);
      t_gv = SumWidth'(p_gv >>> CoefShift);
      t_bu = SumWidth'(p_bu >>> CoefShift);

      y_ext = $signed({3'b000, s1_luma_ff});
      r_sum = y_ext + t_rv;
      g_sum = y_ext - t_gu - t_gv;
      b_sum = y_ext + t_bu;

      rsp_valid_in = s1_move || (rsp_valid_ff && !out_free);
      rsp_blue_in  = rsp_blue_ff;
      rsp_green_in = rsp_green_ff;
      rsp_red_in   = rsp_red_ff;
      if (s1_move) begin
         if (s1_luma_ff == 8'd0) begin
            rsp_blue_in  = '0;
            rsp_green_in = '0;
            rsp_red_in   = '0;
         end else begin
            rsp_blue_in  = clip_channel(b_sum);
            rsp_green_in = clip_channel(g_sum);
            rsp_red_in   = clip_channel(r_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff  <= MODE_WINDOWS;
         swap_chroma_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         color_mode_ff  <= color_mode_in;
         swap_chroma_ff <= swap_chroma_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_luma_ff   <= s1_luma_in;
      s1_first_ff  <= s1_first_in;
      s1_second_ff <= s1_second_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_green_ff <= rsp_green_in;
      rsp_red_ff   <= rsp_red_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = rsp_blue_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_red_out   = rsp_red_ff;

   // A blocked input register keeps its pixel until the result register frees up.
   `Y2R_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !out_free,
      s1_valid_ff && $stable(s1_luma_ff) && $stable(s1_first_ff),
      "input register lost or changed a blocked pixel")

   // A zero luma pixel always comes out black.
   `Y2R_ASSERT_NEXT(a_zero_luma, clock, reset, s1_move && s1_luma_ff == 8'd0,
      rsp_valid_ff && rsp_red_ff == 8'd0 && rsp_green_ff == 8'd0 && rsp_blue_ff == 8'd0,
      "zero luma did not give black")

   // In grey mode the three channels carry the luma unchanged.
   `Y2R_ASSERT_NEXT(a_grey_mode, clock, reset, s1_move && color_mode_ff == MODE_GREY,
      rsp_red_ff == $past(s1_luma_ff) && rsp_green_ff == $past(s1_luma_ff)
         && rsp_blue_ff == $past(s1_luma_ff),
      "grey mode result differs from luma")

endmodule

@@ test/pixel_color_checker.sv @@
// Checker for the YUV to RGB pixel converter: watches both channels and the csr port,
// predicts each RGB pixel from the accepted request and compares it in order.
// Depends on y2r_pkg for register indexes, mode codes and the coefficient shift.
`timescale 1ns / 1ps

module pixel_color_checker
   import y2r_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_luma,
   input  logic [7:0] req_first_chroma,
   input  logic [7:0] req_second_chroma,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_blue_out,
   input  logic [7:0] rsp_green_out,
   input  logic [7:0] rsp_red_out,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [1:0] csr_wdata,
   output int         failures,
   output int         outstanding
);

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_pixel_type;

   logic [1:0] shadow_mode = MODE_WINDOWS;
   logic       shadow_swap = 1'b0;
   rgb_pixel_type expected_pixels[$];
   int         fail_count = 0;
   int         pending_count = 0;

   assign failures    = fail_count;
   assign outstanding = pending_count;

   function automatic int chroma_term(int chroma, int coef);
      return (chroma * coef) >>> CoefShift;
   endfunction

   function automatic logic [7:0] clip_to_byte(int level);
      if (level < 0) begin
         return 8'd0;
      end else if (level > 255) begin
         return 8'd255;
      end
      return level[7:0];
   endfunction

   function automatic rgb_pixel_type convert_pixel(logic [7:0] luma, logic [7:0] first,
                                                   logic [7:0] second, logic [1:0] mode,
                                                   logic swap);
      int y;
      int u;
      int v;
      int rv;
      int gu;
      int gv;
      int bu;
      rgb_pixel_type px;
      y = int'(luma);
      if (swap) begin
         u = int'(first) - 128;
         v = int'(second) - 128;
      end else begin
         v = int'(first) - 128;
         u = int'(second) - 128;
      end
      case (mode)
         MODE_WINDOWS: begin
            rv = 1632; gu = 400; gv = 528; bu = 2064;
         end
         MODE_PAL: begin
            rv = 1168; gu = 408; gv = 594; bu = 2080;
         end
         MODE_V4L2: begin
            rv = 1440; gu = 352; gv = 736; bu = 1816;
         end
         default: begin
            rv = 0; gu = 0; gv = 0; bu = 0;
         end
      endcase
      if (y == 0) begin
         px = '0;
      end else begin
         px.red   = clip_to_byte(y + chroma_term(v, rv));
         px.green = clip_to_byte(y - chroma_term(u, gu) - chroma_term(v, gv));
         px.blue  = clip_to_byte(y + chroma_term(u, bu));
      end
      return px;
   endfunction

   task automatic report_failure(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rgb_pixel_type want;
      if (reset) begin
         shadow_mode = MODE_WINDOWS;
         shadow_swap = 1'b0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_failure("response transfer with no pixel outstanding");
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_blue_out !== want.blue)
                  report_failure($sformatf("blue got %0d, expected %0d",
                                           rsp_blue_out, want.blue));
               if (rsp_green_out !== want.green)
                  report_failure($sformatf("green got %0d, expected %0d",
                                           rsp_green_out, want.green));
               if (rsp_red_out !== want.red)
                  report_failure($sformatf("red got %0d, expected %0d",
                                           rsp_red_out, want.red));
            end
         end
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(convert_pixel(req_luma, req_first_chroma,
                                                    req_second_chroma, shadow_mode,
                                                    shadow_swap));
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COLOR_MODE:  shadow_mode = csr_wdata;
               CSR_SWAP_CHROMA: shadow_swap = csr_wdata[0];
               default: ;
            endcase
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

@@ test/tb.sv @@
// Top of the pixel converter testbench: clock, reset, directed and random pixel
// stimulus across all coefficient modes and plane orders, random stalls and the verdict.
// Depends on y2r_pkg, the yuv_to_rgb_pixel_converter RTL and pixel_color_checker.
`timescale 1ns / 1ps

module tb;
   import y2r_pkg::*;

   localparam int CycleLimit = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_luma = '0;
   logic [7:0] req_first_chroma = '0;
   logic [7:0] req_second_chroma = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_blue_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_red_out;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = CSR_COLOR_MODE;
   logic [1:0] csr_wdata = '0;

   int failures;
   int outstanding;
   int cycle_count = 0;
   bit burst_mode = 1'b0;
   bit long_hold = 1'b0;

   logic [23:0] directed_pixels [19] = '{
      24'h00_00_00, 24'h00_FF_FF, 24'h00_80_00, 24'hFF_FF_FF, 24'hFF_00_00,
      24'hFF_80_80, 24'h01_00_FF, 24'h01_FF_00, 24'h80_80_80, 24'h80_7F_81,
      24'h80_81_7F, 24'h10_00_80, 24'h10_80_00, 24'hEB_FF_80, 24'hEB_80_FF,
      24'h64_7F_7F, 24'h64_81_81, 24'hC8_00_FF, 24'h32_FF_FF
   };

   always #10 clock = ~clock;

   yuv_to_rgb_pixel_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_luma         (req_luma),
      .req_first_chroma (req_first_chroma),
      .req_second_chroma(req_second_chroma),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_red_out      (rsp_red_out),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   pixel_color_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_luma         (req_luma),
      .req_first_chroma (req_first_chroma),
      .req_second_chroma(req_second_chroma),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_red_out      (rsp_red_out),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   function automatic logic [7:0] random_byte();
      case ($urandom_range(11))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd128;
         3: return 8'd127;
         4: return 8'd1;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixel(logic [7:0] luma, logic [7:0] first, logic [7:0] second);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(4);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_luma          <= luma;
      req_first_chroma  <= first;
      req_second_chroma <= second;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_settings(logic [1:0] mode, logic swap);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_COLOR_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      csr_index <= CSR_SWAP_CHROMA;
      csr_wdata <= {1'($urandom_range(1)), swap};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain(int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Response side: short random stalls, and now and then a long hold-off so that
   // the converter fills up and stalls its request channel.
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (64) @(posedge clock);
         end else begin
            hold = burst_mode ? 0 : $urandom_range(4);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int phase;
      int n;
      logic [1:0] mode;
      logic swap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_pixels[i])
         send_pixel(directed_pixels[i][23:16], directed_pixels[i][15:8],
                    directed_pixels[i][7:0]);
      drain(4);
      for (phase = 0; phase < 12; phase++) begin
         if (phase < 8) begin
            mode = phase[1:0];
            swap = phase[2];
         end else begin
            mode = 2'($urandom_range(3));
            swap = 1'($urandom_range(1));
         end
         write_settings(mode, swap);
         burst_mode = ($urandom_range(3) == 0);
         long_hold  = (phase == 2 || phase == 9);
         for (n = 0; n < 115; n++)
            send_pixel(random_byte(), random_byte(), random_byte());
         drain(4);
      end
      drain(8);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/y2r_pkg.sv
rtl/yuv_to_rgb_pixel_converter.sv
test/pixel_color_checker.sv
test/tb.sv
